// ===== hw/rtl/crbd_pkg.sv =====
`timescale 1ns / 1ps
package crbd_pkg;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_CODED     = 3'd1;
  localparam logic [2:0] PH_SIG       = 3'd2;
  localparam logic [2:0] PH_FIRST     = 3'd3;
  localparam logic [2:0] PH_REST      = 3'd4;
  localparam logic [2:0] PH_ESC_UNARY = 3'd5;
  localparam logic [2:0] PH_ESC_BITS  = 3'd6;
  localparam logic [2:0] PH_SIGN      = 3'd7;

  localparam logic [2:0] CLS_CODED  = 3'd0;
  localparam logic [2:0] CLS_SIG    = 3'd1;
  localparam logic [2:0] CLS_LAST   = 3'd2;
  localparam logic [2:0] CLS_LFIRST = 3'd3;
  localparam logic [2:0] CLS_LREST  = 3'd4;
  localparam logic [2:0] CLS_BYPASS = 3'd5;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  localparam logic [2:0] CAT_LUMA4X4 = 3'd2;
  localparam logic [2:0] CAT_CHR_DC  = 3'd3;
  localparam logic [2:0] CAT_MAX     = 3'd4;

  localparam logic [3:0] PREFIX_CAP     = 4'd14;
  localparam logic [4:0] ESC_BASE       = 5'd15;
  localparam logic [4:0] FIRST_CTX_MAX  = 5'd4;
  localparam logic [4:0] REST_CTX_BASE  = 5'd5;

endpackage

// ===== hw/rtl/cabac_residual_block_decode.sv =====
`timescale 1ns / 1ps
// CABAC residual block debinarizer for ctxBlockCat 0..4.
// Input channel (in_valid / in_stall): one transaction is either a block start
// (in_kind low, header fields used) or one decoded bin (in_kind high, in_bin
// holds the value of the bin asked for by the previous result).
// Result channel (out_valid / out_stall): each start and each bin of a running
// block yields one result: the next bin request (class and context increment),
// optionally a finished coefficient in reverse scan order, and on the last
// result of a block out_block_done with the nonzero count. A bin sent while no
// block is running yields no result; a start abandons the running block.
// Each accepted input passes the input register, then the result register, and
// a receiver stall can hold it in either before out_valid shows its result.
// Throughput: one transaction per cycle while the receiver does not stall; the
// decode state is loaded from the input register on the same edge as the result register.
// When the receiver stalls, the result register holds and in_stall rises once
// the input register is also full.
// Reset: rst_n low at a rising clock edge (synchronous) empties both registers and
// returns the decoder to idle with all counters cleared.
module cabac_residual_block_decode #(
  parameter int MAX_COEFFS  = 16,
  parameter int LEVEL_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [2:0]                    in_block_category,
  input  logic [4:0]                    in_coeff_count,
  input  logic                          in_read_coded_flag,
  input  logic [1:0]                    in_coded_flag_inc,
  input  logic                          in_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_need_bin,
  output logic [2:0]                    out_bin_class,
  output logic [4:0]                    out_ctx_inc,
  output logic                          out_coeff_valid,
  output logic [3:0]                    out_coeff_pos,
  output logic signed [LEVEL_WIDTH-1:0] out_coeff_value,
  output logic                          out_block_done,
  output logic [4:0]                    out_nonzero_count
);
  import crbd_pkg::*;

  localparam int IDX_W = $clog2(MAX_COEFFS);
  localparam int CNT_W = $clog2(MAX_COEFFS + 1);
  localparam int ORD_W = $clog2(LEVEL_WIDTH + 1);
  localparam int MAG_W = LEVEL_WIDTH - 1;
  localparam logic [MAG_W-1:0] LEVEL_MAX = {MAG_W{1'b1}};

  function automatic logic [4:0] pos_inc(input logic [2:0] cat, input logic [IDX_W-1:0] idx);
    if (cat == CAT_CHR_DC && idx > IDX_W'(2)) begin
      return 5'd2;
    end
    return 5'(idx);
  endfunction

  function automatic logic [4:0] first_inc(input logic [CNT_W-1:0] clo,
                                           input logic [CNT_W-1:0] clg);
    if (clg != '0) begin
      return 5'd0;
    end
    if (clo >= CNT_W'(3)) begin
      return FIRST_CTX_MAX;
    end
    return 5'(clo) + 5'd1;
  endfunction

  function automatic logic [4:0] rest_inc(input logic [2:0] cat, input logic [CNT_W-1:0] clg);
    logic [CNT_W-1:0] cap;
    cap = (cat == CAT_CHR_DC) ? CNT_W'(3) : CNT_W'(4);
    return REST_CTX_BASE + 5'((clg < cap) ? clg : cap);
  endfunction

  function automatic logic [MAG_W-1:0] sat(input logic [LEVEL_WIDTH-1:0] s);
    return s[LEVEL_WIDTH-1] ? LEVEL_MAX : s[MAG_W-1:0];
  endfunction

  // input register
  logic       in_valid_r;
  logic       kind_r;
  logic [2:0] cat_in_r;
  logic [4:0] cnt_in_r;
  logic       read_coded_r;
  logic [1:0] coded_inc_r;
  logic       bin_r;

  // decode state
  logic [2:0]            phase_r, phase_nxt;
  logic [IDX_W-1:0]      scan_index_r, scan_index_nxt;
  logic [MAX_COEFFS-1:0] sig_map_r, sig_map_nxt;
  logic [CNT_W-1:0]      cnt_one_r, cnt_one_nxt;
  logic [CNT_W-1:0]      cnt_gt_r, cnt_gt_nxt;
  logic [3:0]            prefix_ones_r, prefix_ones_nxt;
  logic [ORD_W-1:0]      esc_order_r, esc_order_nxt;
  logic [MAG_W-1:0]      esc_value_r, esc_value_nxt;
  logic [MAG_W-1:0]      cur_level_r, cur_level_nxt;
  logic [4:0]            nz_tally_r, nz_tally_nxt;
  logic [2:0]            held_cat_r, held_cat_nxt;
  logic [CNT_W-1:0]      held_cnt_r, held_cnt_nxt;

  // result register
  logic                   out_valid_r;
  logic                   need_r, need_nxt;
  logic [2:0]             class_r, class_nxt;
  logic [4:0]             inc_r, inc_nxt;
  logic                   cv_r, cv_nxt;
  logic [3:0]             pos_r, pos_nxt;
  logic [LEVEL_WIDTH-1:0] val_r, val_nxt;
  logic                   done_r, done_nxt;
  logic [4:0]             nz_r, nz_nxt;

  logic produce;
  logic out_free;
  logic take;
  logic fire;

  assign produce  = (kind_r == KIND_START) || (phase_r != PH_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign take     = !produce || out_free;
  assign fire     = in_valid_r && produce && out_free;
  assign in_stall = in_valid_r && !take;

  always_comb begin
    logic                   start_map;
    logic                   advance;
    logic                   close_map;
    logic                   ask_first;
    logic                   ask_rest;
    logic                   go_sign;
    logic                   found;
    logic [IDX_W-1:0]       found_pos;
    logic [MAG_W-1:0]       sign_level;
    logic [MAG_W-1:0]       esc_b;
    logic [IDX_W-1:0]       scan_inc;
    logic [LEVEL_WIDTH-1:0] mag_x;

    start_map  = 1'b0;
    advance    = 1'b0;
    close_map  = 1'b0;
    ask_first  = 1'b0;
    ask_rest   = 1'b0;
    go_sign    = 1'b0;
    found      = 1'b0;
    found_pos  = '0;
    sign_level = '0;
    esc_b      = esc_value_r;
    scan_inc   = scan_index_r + IDX_W'(1);
    mag_x      = {1'b0, cur_level_r};

    phase_nxt       = phase_r;
    scan_index_nxt  = scan_index_r;
    sig_map_nxt     = sig_map_r;
    cnt_one_nxt     = cnt_one_r;
    cnt_gt_nxt      = cnt_gt_r;
    prefix_ones_nxt = prefix_ones_r;
    esc_order_nxt   = esc_order_r;
    esc_value_nxt   = esc_value_r;
    cur_level_nxt   = cur_level_r;
    nz_tally_nxt    = nz_tally_r;
    held_cat_nxt    = held_cat_r;
    held_cnt_nxt    = held_cnt_r;

    need_nxt  = 1'b0;
    class_nxt = '0;
    inc_nxt   = '0;
    cv_nxt    = 1'b0;
    pos_nxt   = '0;
    val_nxt   = '0;
    done_nxt  = 1'b0;
    nz_nxt    = '0;

    if (kind_r == KIND_START) begin
      held_cat_nxt = (cat_in_r > CAT_MAX) ? CAT_LUMA4X4 : cat_in_r;
      if (cnt_in_r == 5'd0) begin
        held_cnt_nxt = CNT_W'(1);
      end else if (cnt_in_r > 5'(MAX_COEFFS)) begin
        held_cnt_nxt = CNT_W'(MAX_COEFFS);
      end else begin
        held_cnt_nxt = CNT_W'(cnt_in_r);
      end
      cnt_one_nxt  = '0;
      cnt_gt_nxt   = '0;
      nz_tally_nxt = '0;
      sig_map_nxt  = '0;
      if (read_coded_r) begin
        phase_nxt      = PH_CODED;
        scan_index_nxt = '0;
        need_nxt       = 1'b1;
        class_nxt      = CLS_CODED;
        inc_nxt        = {held_cat_nxt, coded_inc_r};
      end else begin
        start_map = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_CODED: begin
          if (bin_r) begin
            start_map = 1'b1;
          end else begin
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SIG: begin
          if (!sig_map_r[scan_index_r]) begin
            if (bin_r) begin
              sig_map_nxt[scan_index_r] = 1'b1;
              need_nxt  = 1'b1;
              class_nxt = CLS_LAST;
              inc_nxt   = pos_inc(held_cat_r, scan_index_r);
            end else begin
              advance = 1'b1;
            end
          end else if (bin_r) begin
            ask_first = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
        PH_FIRST: begin
          if (bin_r) begin
            prefix_ones_nxt = 4'd1;
            ask_rest        = 1'b1;
          end else begin
            go_sign    = 1'b1;
            sign_level = MAG_W'(1);
          end
        end
        PH_REST: begin
          if (bin_r) begin
            prefix_ones_nxt = prefix_ones_r + 4'd1;
            if (prefix_ones_nxt >= PREFIX_CAP) begin
              phase_nxt     = PH_ESC_UNARY;
              esc_order_nxt = '0;
              esc_value_nxt = '0;
              need_nxt      = 1'b1;
              class_nxt     = CLS_BYPASS;
            end else begin
              ask_rest = 1'b1;
            end
          end else begin
            go_sign    = 1'b1;
            sign_level = MAG_W'(prefix_ones_r) + MAG_W'(1);
          end
        end
        PH_ESC_UNARY: begin
          if (bin_r) begin
            if (esc_order_r < ORD_W'(LEVEL_WIDTH)) begin
              esc_value_nxt = sat({1'b0, esc_value_r} + (LEVEL_WIDTH'(1) << esc_order_r));
              esc_order_nxt = esc_order_r + ORD_W'(1);
            end else begin
              esc_value_nxt = LEVEL_MAX;
            end
            need_nxt  = 1'b1;
            class_nxt = CLS_BYPASS;
          end else if (esc_order_r == '0) begin
            go_sign    = 1'b1;
            sign_level = sat({1'b0, esc_value_r} + LEVEL_WIDTH'(ESC_BASE));
          end else begin
            phase_nxt = PH_ESC_BITS;
            need_nxt  = 1'b1;
            class_nxt = CLS_BYPASS;
          end
        end
        PH_ESC_BITS: begin
          esc_order_nxt = esc_order_r - ORD_W'(1);
          if (bin_r) begin
            esc_b = sat({1'b0, esc_value_r} + (LEVEL_WIDTH'(1) << esc_order_nxt));
          end
          esc_value_nxt = esc_b;
          if (esc_order_nxt == '0) begin
            go_sign    = 1'b1;
            sign_level = sat({1'b0, esc_b} + LEVEL_WIDTH'(ESC_BASE));
          end else begin
            need_nxt  = 1'b1;
            class_nxt = CLS_BYPASS;
          end
        end
        PH_SIGN: begin
          cv_nxt       = 1'b1;
          pos_nxt      = 4'(scan_index_r);
          val_nxt      = bin_r ? (~mag_x + LEVEL_WIDTH'(1)) : mag_x;
          nz_tally_nxt = nz_tally_r + 5'd1;
          if (cur_level_r > MAG_W'(1)) begin
            cnt_gt_nxt = cnt_gt_r + CNT_W'(1);
          end else begin
            cnt_one_nxt = cnt_one_r + CNT_W'(1);
          end
          for (int p = 0; p < MAX_COEFFS; p++) begin
            if (IDX_W'(p) < scan_index_r && sig_map_r[p]) begin
              found     = 1'b1;
              found_pos = IDX_W'(p);
            end
          end
          if (found) begin
            scan_index_nxt = found_pos;
            ask_first      = 1'b1;
          end else begin
            done_nxt  = 1'b1;
            nz_nxt    = nz_tally_nxt;
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end

    if (start_map) begin
      scan_index_nxt = '0;
      sig_map_nxt    = '0;
      if (held_cnt_nxt <= CNT_W'(1)) begin
        close_map = 1'b1;
      end else begin
        phase_nxt = PH_SIG;
        need_nxt  = 1'b1;
        class_nxt = CLS_SIG;
        inc_nxt   = 5'd0;
      end
    end

    if (advance) begin
      scan_index_nxt = scan_inc;
      if (CNT_W'(scan_index_r) + CNT_W'(1) >= held_cnt_r - CNT_W'(1)) begin
        close_map = 1'b1;
      end else begin
        phase_nxt = PH_SIG;
        need_nxt  = 1'b1;
        class_nxt = CLS_SIG;
        inc_nxt   = pos_inc(held_cat_r, scan_inc);
      end
    end

    if (close_map) begin
      scan_index_nxt              = IDX_W'(held_cnt_nxt - CNT_W'(1));
      sig_map_nxt[scan_index_nxt] = 1'b1;
      ask_first                   = 1'b1;
    end

    if (ask_first) begin
      phase_nxt       = PH_FIRST;
      prefix_ones_nxt = '0;
      esc_order_nxt   = '0;
      esc_value_nxt   = '0;
      cur_level_nxt   = MAG_W'(1);
      need_nxt        = 1'b1;
      class_nxt       = CLS_LFIRST;
      inc_nxt         = first_inc(cnt_one_nxt, cnt_gt_nxt);
    end

    if (ask_rest) begin
      phase_nxt = PH_REST;
      need_nxt  = 1'b1;
      class_nxt = CLS_LREST;
      inc_nxt   = rest_inc(held_cat_r, cnt_gt_r);
    end

    if (go_sign) begin
      cur_level_nxt = sign_level;
      phase_nxt     = PH_SIGN;
      need_nxt      = 1'b1;
      class_nxt     = CLS_BYPASS;
      inc_nxt       = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r       <= in_kind;
      cat_in_r     <= in_block_category;
      cnt_in_r     <= in_coeff_count;
      read_coded_r <= in_read_coded_flag;
      coded_inc_r  <= in_coded_flag_inc;
      bin_r        <= in_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      scan_index_r  <= '0;
      sig_map_r     <= '0;
      cnt_one_r     <= '0;
      cnt_gt_r      <= '0;
      prefix_ones_r <= '0;
      esc_order_r   <= '0;
      esc_value_r   <= '0;
      cur_level_r   <= '0;
      nz_tally_r    <= '0;
      held_cat_r    <= '0;
      held_cnt_r    <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      scan_index_r  <= scan_index_nxt;
      sig_map_r     <= sig_map_nxt;
      cnt_one_r     <= cnt_one_nxt;
      cnt_gt_r      <= cnt_gt_nxt;
      prefix_ones_r <= prefix_ones_nxt;
      esc_order_r   <= esc_order_nxt;
      esc_value_r   <= esc_value_nxt;
      cur_level_r   <= cur_level_nxt;
      nz_tally_r    <= nz_tally_nxt;
      held_cat_r    <= held_cat_nxt;
      held_cnt_r    <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      need_r  <= need_nxt;
      class_r <= class_nxt;
      inc_r   <= inc_nxt;
      cv_r    <= cv_nxt;
      pos_r   <= pos_nxt;
      val_r   <= val_nxt;
      done_r  <= done_nxt;
      nz_r    <= nz_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_need_bin      = need_r;
  assign out_bin_class     = class_r;
  assign out_ctx_inc       = inc_r;
  assign out_coeff_valid   = cv_r;
  assign out_coeff_pos     = pos_r;
  assign out_coeff_value   = signed'(val_r);
  assign out_block_done    = done_r;
  assign out_nonzero_count = nz_r;

  a_done_no_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !need_r)
    else $error("block done result also requests a bin");

  a_coeff_then_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cv_r && !done_r |-> need_r && class_r == CLS_LFIRST)
    else $error("coefficient not followed by a level prefix request");

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> CNT_W'(nz_tally_r) <= held_cnt_r)
    else $error("nonzero tally exceeds block size");

  a_escape_order: assert property (@(posedge clk) disable iff (!rst_n)
    esc_order_r <= ORD_W'(LEVEL_WIDTH))
    else $error("escape order out of range");

endmodule
